### rtl/sab_pkg.sv
package sab_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;

    localparam int unsigned SUM_W   = 32;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned COL_W   = 16;
    localparam int unsigned CFG_W   = 9;
    localparam int unsigned LANES   = 3;

    localparam logic [1:0] OP_ACC   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Start and done between the sequencer and one divider lane.
    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

### rtl/sample_accumulation_buffer_unit.sv
// Channel  | Dir | Fields (low bit up)
// s_axis   | in  | tdata: opcode, coord_x, coord_y, red_in, green_in, blue_in
// m_axis   | out | tdata: red_avg, green_avg, blue_avg, samples_seen; tuser: empty_pixel
// cfg      | in  | index 0 frame_width, 1 frame_height
//
// Accumulate and clear: address, memory read, add (or zero for clear) and write back. A
// read runs in the three divider lanes (32 quotient bits), then waits for the output
// register to be free. A read of an empty pixel skips the division, and an ignored
// opcode leaves the unit idle. Items are taken only while idle, one at a time. After
// reset a clearing pass sweeps MAX_WIDTH*MAX_HEIGHT entries, one a cycle, with no item
// accepted. A result waits in the output register.
module sample_accumulation_buffer_unit #(
    parameter int unsigned MAX_WIDTH  = sab_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = sab_pkg::DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // opcode, coord_x, coord_y, red_in, green_in, blue_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // red_avg, green_avg, blue_avg, samples_seen
    output logic        m_axis_tuser,   // empty_pixel
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int unsigned PIXELS = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int unsigned XW     = $clog2(MAX_WIDTH + 1);
    localparam int unsigned YW     = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned SW     = sab_pkg::SUM_W;
    localparam int unsigned CW     = sab_pkg::CNT_W;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_MOD  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // Configuration registers.
    logic [8:0] r_fw, r_fh;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= 9'd256;
            r_fh <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sab_pkg::CFG_WIDTH:  r_fw <= i_cfg_data;
                sab_pkg::CFG_HEIGHT: r_fh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective limits.
    logic [XW-1:0] lim_w;
    logic [YW-1:0] lim_h;
    always_comb begin
        if (r_fw == '0) lim_w = XW'(1);
        else if (32'(r_fw) > MAX_WIDTH) lim_w = XW'(MAX_WIDTH);
        else lim_w = XW'(r_fw);
        if (r_fh == '0) lim_h = YW'(1);
        else if (32'(r_fh) > MAX_HEIGHT) lim_h = YW'(MAX_HEIGHT);
        else lim_h = YW'(r_fh);
    end

    logic [1:0]  in_op;
    logic signed [15:0] in_x, in_y;
    assign in_op = s_axis_tdata[1:0];
    assign in_x  = s_axis_tdata[17:2];
    assign in_y  = s_axis_tdata[33:18];

    // Clamp coordinates.
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    always_comb begin
        if (in_x < 0) cx = '0;
        else if (17'(in_x) >= 17'(lim_w)) cx = lim_w - 1'b1;
        else cx = XW'(in_x);
        if (in_y < 0) cy = '0;
        else if (17'(in_y) >= 17'(lim_h)) cy = lim_h - 1'b1;
        else cy = YW'(in_y);
    end

    logic [2:0]        r_st;
    logic [AW-1:0]     r_clr;
    logic [1:0]        r_op;
    logic [XW-1:0]     r_x, r_w;
    logic [YW-1:0]     r_y;
    logic [AW-1:0]     r_addr;
    logic [47:0]       r_col;
    logic              r_ov;
    logic [XW+YW-1:0]  full_a;

    assign full_a = (XW+YW)'(r_x) + (XW+YW)'(r_y) * (XW+YW)'(r_w);

    // Pixel memories.
    logic [SW-1:0] mem_r [PIXELS];
    logic [SW-1:0] mem_g [PIXELS];
    logic [SW-1:0] mem_b [PIXELS];
    logic [CW-1:0] mem_c [PIXELS];
    logic [SW-1:0] r_rs, r_gs, r_bs;
    logic [CW-1:0] r_cs;
    logic          we;
    logic [AW-1:0] waddr;
    logic [SW-1:0] wr, wg, wb;
    logic [CW-1:0] wc;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_r[waddr] <= wr;
            mem_g[waddr] <= wg;
            mem_b[waddr] <= wb;
            mem_c[waddr] <= wc;
        end
        r_rs <= mem_r[r_addr];
        r_gs <= mem_g[r_addr];
        r_bs <= mem_b[r_addr];
        r_cs <= mem_c[r_addr];
    end

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [15:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + (SW+1)'(b);
        return s[SW] ? '1 : s[SW-1:0];
    endfunction

    // Write port selection.
    always_comb begin
        we = 1'b0; waddr = r_addr; wr = '0; wg = '0; wb = '0; wc = '0;
        if (r_st == ST_CLR) begin
            we = 1'b1; waddr = r_clr;
        end else if (r_st == ST_MOD) begin
            if (r_op == sab_pkg::OP_ACC && r_cs != '1) begin
                we = 1'b1;
                wr = sat_add(r_rs, r_col[15:0]);
                wg = sat_add(r_gs, r_col[31:16]);
                wb = sat_add(r_bs, r_col[47:32]);
                wc = r_cs + 1'b1;
            end else if (r_op == sab_pkg::OP_CLEAR) begin
                we = 1'b1;
            end
        end
    end

    // Divider lanes.
    sab_pkg::t_div_ctl ctl [sab_pkg::LANES];
    logic [15:0] avg [sab_pkg::LANES];
    logic [SW-1:0] lsum [sab_pkg::LANES];
    assign lsum[0] = r_rs;
    assign lsum[1] = r_gs;
    assign lsum[2] = r_bs;

    for (genvar g = 0; g < sab_pkg::LANES; g++) begin : g_lane
        assign ctl[g].start = (r_st == ST_MOD) && (r_op == sab_pkg::OP_READ) && (r_cs != '0);
        sab_divider u_div (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_start(ctl[g].start),
            .i_sum  (lsum[g]),
            .i_cnt  (r_cs),
            .o_done (ctl[g].done),
            .o_avg  (avg[g])
        );
    end

    logic [63:0] r_out;
    logic        r_empty, r_oval;
    logic        load_out;

    assign s_axis_tready = (r_st == ST_IDLE);
    assign load_out      = (r_st == ST_OUT) && (!r_oval || m_axis_tready);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_CLR;
            r_clr  <= '0;
        end else begin
            case (r_st)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == PIXELS - 1) r_st <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op  <= in_op;
                        r_x   <= cx;
                        r_y   <= cy;
                        r_w   <= lim_w;
                        r_col <= s_axis_tdata[81:34];
                        r_st  <= (in_op == sab_pkg::OP_NONE) ? ST_IDLE : ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    r_ov   <= 32'(full_a) >= PIXELS;
                    r_addr <= AW'(full_a);
                    r_st   <= ST_RD;
                end
                ST_RD: r_st <= r_ov ? ST_IDLE : ST_MOD;
                ST_MOD: begin
                    if (r_op != sab_pkg::OP_READ) r_st <= ST_IDLE;
                    else if (r_cs == '0) r_st <= ST_OUT;
                    else r_st <= ST_DIV;
                end
                ST_DIV: begin
                    if (ctl[0].done && ctl[1].done && ctl[2].done) r_st <= ST_OUT;
                end
                ST_OUT: begin
                    if (load_out) r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // Output register; the lane results are merged once the previous item has gone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (load_out) begin
            r_oval <= 1'b1;
            if (r_cs == '0) begin
                r_out   <= '0;
                r_empty <= 1'b1;
            end else begin
                r_out   <= {r_cs, avg[2], avg[1], avg[0]};
                r_empty <= 1'b0;
            end
        end else if (m_axis_tready) begin
            r_oval <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_empty;

endmodule

### rtl/sab_divider.sv
// Restoring divider, one quotient bit a cycle; quotient saturated to 16 bits.
module sab_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sab_pkg::SUM_W-1:0]   i_sum,
    input  logic [sab_pkg::CNT_W-1:0]   i_cnt,
    output logic                        o_done,
    output logic [sab_pkg::COL_W-1:0]   o_avg
);

    localparam int unsigned CW = $clog2(sab_pkg::SUM_W + 1);

    logic [sab_pkg::SUM_W-1:0] r_quo, n_quo;
    logic [sab_pkg::CNT_W:0]   r_rem, n_rem;
    logic [sab_pkg::CNT_W-1:0] r_den;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy, r_done;
    logic [sab_pkg::CNT_W:0]   trial;

    // One shift and subtract step.
    always_comb begin
        trial = {r_rem[sab_pkg::CNT_W-1:0], r_quo[sab_pkg::SUM_W-1]};
        n_quo = {r_quo[sab_pkg::SUM_W-2:0], 1'b0};
        n_rem = trial;
        if (trial >= {1'b0, r_den}) begin
            n_rem    = trial - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_quo  <= i_sum;
            r_rem  <= '0;
            r_den  <= i_cnt;
            r_cnt  <= CW'(sab_pkg::SUM_W);
        end else if (r_busy) begin
            r_quo  <= n_quo;
            r_rem  <= n_rem;
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CW'(1));
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_avg  = (|r_quo[sab_pkg::SUM_W-1:sab_pkg::COL_W]) ? '1
                                                              : r_quo[sab_pkg::COL_W-1:0];

endmodule
